@@ sv/vnc_pkg.sv @@
// Shared constants, types and the cosine weight table of the value noise classifier.
`timescale 1ns / 1ps
package vnc_pkg;

  // Lattice geometry. Both sides must be powers of two: cell indexes wrap by masking.
  localparam int LATTICE_ROWS   = 64;
  localparam int LATTICE_COLS   = 64;
  localparam int MAX_OCTAVES    = 8;
  localparam int MAX_WINDOW     = 16;
  localparam int COS_TABLE_BITS = 10;

  localparam int ROW_BITS     = $clog2(LATTICE_ROWS);
  localparam int COL_BITS     = $clog2(LATTICE_COLS);
  localparam int ADDR_BITS    = ROW_BITS + COL_BITS;
  localparam int LATTICE_SIZE = LATTICE_ROWS * LATTICE_COLS;
  localparam int ROM_SIZE     = 1 << COS_TABLE_BITS;

  // Field widths of the beats and registers.
  localparam int IDX_W   = 12;
  localparam int VAL_W   = 16;
  localparam int CRD_W   = 16;
  localparam int STEP_W  = 16;
  localparam int OCTC_W  = 4;
  localparam int PERS_W  = 16;
  localparam int THR_W   = 16;
  localparam int WINC_W  = 5;
  localparam int CLASS_W = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // Loop counters and accumulators.
  localparam int OCT_CNT_W = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
  localparam int OCT_W     = $clog2(MAX_OCTAVES + 1);
  localparam int WIN_CNT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WIN_W     = $clog2(MAX_WINDOW + 1);
  localparam int AREA_W    = 2 * WIN_W;
  localparam int AMP_W     = 17;
  localparam int WGT_W     = 17;
  localparam int SUM_W     = AMP_W + VAL_W + OCT_W;
  localparam int TOT_W     = AMP_W + OCT_W;
  localparam int SM_W      = VAL_W + AREA_W;
  localparam int XS_W      = ROW_BITS + MAX_OCTAVES - 1;
  localparam int YS_W      = COL_BITS + MAX_OCTAVES - 1;
  localparam int CS_W      = (XS_W > YS_W) ? XS_W : YS_W;
  localparam int DVD_A     = (CS_W + 16 > SUM_W) ? CS_W + 16 : SUM_W;
  localparam int DVD_W     = (DVD_A > SM_W) ? DVD_A : SM_W;
  localparam int DVS_A     = (TOT_W > STEP_W) ? TOT_W : STEP_W;
  localparam int DVS_W     = (DVS_A > AREA_W) ? DVS_A : AREA_W;
  localparam int DCNT_W    = $clog2(DVD_W + 1);

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [VAL_W:0] BAND_NARROW = 17'd3277;
  localparam logic [VAL_W:0] BAND_WIDE   = 17'd32768;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_CELL_STEP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OCTAVES     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERSISTENCE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THR_LOW     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THR_HIGH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW      = 3'd5;

  typedef enum logic [CLASS_W-1:0] {
    CLS_BELOW  = 3'd0,
    CLS_NARROW = 3'd1,
    CLS_MID    = 3'd2,
    CLS_UPPER  = 3'd3,
    CLS_TOP    = 3'd4
  } tile_class_t;

  typedef enum logic [1:0] {
    DIV_X      = 2'd0,
    DIV_Y      = 2'd1,
    DIV_POINT  = 2'd2,
    DIV_WINDOW = 2'd3
  } div_sel_t;

  typedef enum logic [1:0] {
    CRN_00 = 2'd0,
    CRN_10 = 2'd1,
    CRN_01 = 2'd2,
    CRN_11 = 2'd3
  } corner_t;

  typedef enum logic [1:0] {
    BLD_R1 = 2'd0,
    BLD_R2 = 2'd1,
    BLD_N  = 2'd2
  } blend_sel_t;

  typedef struct packed {
    logic [STEP_W-1:0] cell_step;
    logic [OCTC_W-1:0] octave_count;
    logic [PERS_W-1:0] persistence;
    logic [THR_W-1:0]  threshold_low;
    logic [THR_W-1:0]  threshold_high;
    logic [WINC_W-1:0] window_size;
  } cfg_t;

  typedef struct packed {
    logic       query_init;
    logic       oct_init;
    logic       div_go;
    div_sel_t   div_sel;
    logic       cap_x;
    logic       cap_y;
    logic       rd_en;
    corner_t    rd_sel;
    logic       cap_en;
    corner_t    cap_sel;
    logic       blend_en;
    blend_sel_t blend_sel;
    logic       acc_en;
    logic       pacc_en;
    logic       pt_next;
    logic       cap_v;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic in_range;
    logic last_k;
    logic last_pt;
    logic out_free;
  } sts_t;

  typedef logic [WGT_W-1:0] weight_t;
  typedef weight_t weight_rom_t [ROM_SIZE];

  // Weight w(u) = sin^2(pi*u/2) in Q16 from a truncated Q30 Taylor series.
  // Term n of the series is divided by (2n)(2n+1): 6, 20, 42, 72, 110, 156, 210.
  function automatic weight_rom_t build_weight_rom();
    weight_rom_t rom;
    logic [63:0] th;
    logic [63:0] th2;
    logic [63:0] term;
    logic [63:0] s;
    logic [63:0] tq;
    for (int e = 0; e < ROM_SIZE; e++) begin
      th   = (64'(e) * HALF_PI_Q30) >> COS_TABLE_BITS;
      th2  = (th * th) >> 30;
      term = th;
      s    = th;
      for (int n = 1; n <= 7; n++) begin
        tq = (term * th2) >> 30;
        case (n)
          1:       term = tq / 64'd6;
          2:       term = tq / 64'd20;
          3:       term = tq / 64'd42;
          4:       term = tq / 64'd72;
          5:       term = tq / 64'd110;
          6:       term = tq / 64'd156;
          default: term = tq / 64'd210;
        endcase
        if ((n % 2) == 1) begin
          s = s - term;
        end else begin
          s = s + term;
        end
      end
      s      = (s * s) >> 30;
      rom[e] = WGT_W'((s + 64'd8192) >> 14);
    end
    return rom;
  endfunction

  localparam weight_rom_t WEIGHT_ROM = build_weight_rom();

endpackage

@@ sv/vnc_div.sv @@
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
module vnc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [vnc_pkg::DVD_W-1:0]  dividend,
  input  logic [vnc_pkg::DVS_W-1:0]  divisor,
  output logic                       done,
  output logic [vnc_pkg::DVD_W-1:0]  quotient
);
  import vnc_pkg::*;

  logic [DVD_W-1:0]  quo_r, quo_nxt;
  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [DVS_W-1:0]  dvs_r;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;
  logic              ge;

  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = DCNT_W'(DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ sv/vnc_dp.sv @@
// Datapath: lattice memory, divider, blend unit, accumulators and result register.
`timescale 1ns / 1ps
module vnc_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  vnc_pkg::cfg_t                 cfg,
  input  vnc_pkg::cmd_t                 cmd,
  output vnc_pkg::sts_t                 sts,
  input  logic                          wr_en,
  input  logic [vnc_pkg::IDX_W-1:0]     wr_idx,
  input  logic [vnc_pkg::VAL_W-1:0]     wr_val,
  input  logic [vnc_pkg::CRD_W-1:0]     coord_x,
  input  logic [vnc_pkg::CRD_W-1:0]     coord_y,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [vnc_pkg::VAL_W-1:0]     out_noise,
  output logic [vnc_pkg::CLASS_W-1:0]   out_class
);
  import vnc_pkg::*;

  // Lattice store: one write port, one registered read port.
  logic [VAL_W-1:0]     lattice_mem [LATTICE_SIZE];
  logic [VAL_W-1:0]     rd_data_r;
  logic [ADDR_BITS-1:0] rd_addr;

  logic [CRD_W-1:0]     x0_r, y0_r;
  logic [WIN_CNT_W-1:0] di_r, dj_r;
  logic [OCT_CNT_W-1:0] k_r;
  logic [ROW_BITS-1:0]  ci_r;
  logic [COL_BITS-1:0]  cj_r;
  logic [WGT_W-1:0]     wx_r, wy_r;
  logic [VAL_W-1:0]     c00_r, c10_r, c01_r, c11_r;
  logic [VAL_W-1:0]     r1_r, r2_r, n_r;
  logic [AMP_W-1:0]     amp_r;
  logic [SUM_W-1:0]     sum_r;
  logic [TOT_W-1:0]     total_r;
  logic [SM_W-1:0]      sm_r;
  logic                 out_valid_r;
  logic [VAL_W-1:0]     out_noise_r;
  logic [CLASS_W-1:0]   out_class_r;

  // Sanitized configuration.
  logic [STEP_W-1:0] step;
  logic [5:0]        octs;
  logic [6:0]        win;
  logic [AREA_W-1:0] area;

  always_comb begin
    step = (cfg.cell_step == '0) ? STEP_W'(1) : cfg.cell_step;
    if (cfg.octave_count == '0) begin
      octs = 6'd1;
    end else if (6'(cfg.octave_count) > 6'(MAX_OCTAVES)) begin
      octs = 6'(MAX_OCTAVES);
    end else begin
      octs = 6'(cfg.octave_count);
    end
    if (cfg.window_size == '0) begin
      win = 7'd1;
    end else if (7'(cfg.window_size) > 7'(MAX_WINDOW)) begin
      win = 7'(MAX_WINDOW);
    end else begin
      win = 7'(cfg.window_size);
    end
    area = AREA_W'(win) * AREA_W'(win);
  end

  // Current window point and its shifted coordinates for octave k.
  logic [CRD_W:0]     pt_row, pt_col;
  logic [XS_W-1:0]    xs;
  logic [YS_W-1:0]    ys;

  assign pt_row = {1'b0, x0_r} + (CRD_W+1)'(di_r);
  assign pt_col = {1'b0, y0_r} + (CRD_W+1)'(dj_r);
  assign xs     = XS_W'(pt_row[ROW_BITS-1:0]) << k_r;
  assign ys     = YS_W'(pt_col[COL_BITS-1:0]) << k_r;

  assign sts.in_range = (pt_row < (CRD_W+1)'(LATTICE_ROWS)) &&
                        (pt_col < (CRD_W+1)'(LATTICE_COLS));
  assign sts.last_k   = (6'(k_r) + 6'd1) == octs;
  assign sts.last_pt  = ((7'(di_r) + 7'd1) == win) && ((7'(dj_r) + 7'd1) == win);
  assign sts.out_free = !out_valid_r || out_ready;

  // Divider operands.
  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] dvs;
  logic [DVD_W-1:0] quo;
  logic             div_done;

  always_comb begin
    case (cmd.div_sel)
      DIV_X: begin
        dvd = DVD_W'(xs) << 16;
        dvs = DVS_W'(step);
      end
      DIV_Y: begin
        dvd = DVD_W'(ys) << 16;
        dvs = DVS_W'(step);
      end
      DIV_POINT: begin
        dvd = DVD_W'(sum_r) + DVD_W'(total_r >> 1);
        dvs = DVS_W'(total_r);
      end
      default: begin
        dvd = DVD_W'(sm_r) + DVD_W'(area >> 1);
        dvs = DVS_W'(area);
      end
    endcase
  end

  vnc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_go),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (quo)
  );

  assign sts.div_done = div_done;

  // Fraction bits of the quotient index the weight table.
  logic [WGT_W-1:0] rom_w;
  assign rom_w = WEIGHT_ROM[quo[15 -: COS_TABLE_BITS]];

  // Corner addresses; +1 neighbors wrap within the lattice.
  logic [ROW_BITS-1:0] row_sel;
  logic [COL_BITS-1:0] col_sel;

  always_comb begin
    case (cmd.rd_sel)
      CRN_00: begin
        row_sel = ci_r;
        col_sel = cj_r;
      end
      CRN_10: begin
        row_sel = ci_r + 1'b1;
        col_sel = cj_r;
      end
      CRN_01: begin
        row_sel = ci_r;
        col_sel = cj_r + 1'b1;
      end
      default: begin
        row_sel = ci_r + 1'b1;
        col_sel = cj_r + 1'b1;
      end
    endcase
    rd_addr = {row_sel, col_sel};
  end

  always_ff @(posedge clk) begin
    if (wr_en && ((IDX_W+1)'(wr_idx) < (IDX_W+1)'(LATTICE_SIZE))) begin
      lattice_mem[wr_idx[ADDR_BITS-1:0]] <= wr_val;
    end
    if (cmd.rd_en) begin
      rd_data_r <= lattice_mem[rd_addr];
    end
  end

  // Blend unit: a + (((b - a) * w + 0.5) >> 16), same as the two-product form.
  logic [VAL_W-1:0]        bl_a, bl_b, bl_res;
  logic [WGT_W-1:0]        bl_w;
  logic signed [VAL_W+1:0] bl_d;
  logic signed [2*VAL_W+3:0] bl_p;
  logic signed [2*VAL_W+3:0] bl_s;
  logic [VAL_W+1:0]        bl_sum;

  always_comb begin
    case (cmd.blend_sel)
      BLD_R1: begin
        bl_a = c00_r;
        bl_b = c10_r;
        bl_w = wx_r;
      end
      BLD_R2: begin
        bl_a = c01_r;
        bl_b = c11_r;
        bl_w = wx_r;
      end
      default: begin
        bl_a = r1_r;
        bl_b = r2_r;
        bl_w = wy_r;
      end
    endcase
    bl_d   = $signed({2'b00, bl_b}) - $signed({2'b00, bl_a});
    bl_p   = bl_d * $signed({1'b0, bl_w});
    bl_s   = (bl_p + (2*VAL_W+4)'(32768)) >>> 16;
    bl_sum = {2'b00, bl_a} + bl_s[VAL_W+1:0];
    bl_res = bl_sum[VAL_W-1:0];
  end

  // Octave accumulation and amplitude update.
  logic [AMP_W+VAL_W-1:0]  wprod;
  logic [AMP_W+PERS_W:0]   aprod;

  assign wprod = AMP_W'(amp_r) * (AMP_W+VAL_W)'(n_r);
  assign aprod = (AMP_W+PERS_W+1)'(amp_r) * (AMP_W+PERS_W+1)'(cfg.persistence)
               + (AMP_W+PERS_W+1)'(32768);

  // Classification of the window average.
  logic [VAL_W-1:0]   v;
  logic [VAL_W:0]     lo_n, hi_w;
  tile_class_t        cls;

  assign v    = quo[VAL_W-1:0];
  assign lo_n = {1'b0, cfg.threshold_low} + BAND_NARROW;
  assign hi_w = {1'b0, cfg.threshold_high} + BAND_WIDE;

  always_comb begin
    if (v < cfg.threshold_low) begin
      cls = CLS_BELOW;
    end else if ((v > cfg.threshold_low) && ({1'b0, v} < lo_n)) begin
      cls = CLS_NARROW;
    end else if ((v > cfg.threshold_low) && (v < cfg.threshold_high)) begin
      cls = CLS_MID;
    end else if ((v > cfg.threshold_high) && ({1'b0, v} < hi_w)) begin
      cls = CLS_UPPER;
    end else begin
      cls = CLS_TOP;
    end
  end

  logic [VAL_W-1:0]   v_r;
  logic [CLASS_W-1:0] cls_r;

  always_ff @(posedge clk) begin
    if (cmd.query_init) begin
      x0_r <= coord_x;
      y0_r <= coord_y;
      sm_r <= '0;
    end
    if (cmd.oct_init) begin
      amp_r   <= AMP_W'(65536);
      sum_r   <= '0;
      total_r <= '0;
    end
    if (cmd.cap_x) begin
      ci_r <= quo[16 +: ROW_BITS];
      wx_r <= rom_w;
    end
    if (cmd.cap_y) begin
      cj_r <= quo[16 +: COL_BITS];
      wy_r <= rom_w;
    end
    if (cmd.cap_en) begin
      case (cmd.cap_sel)
        CRN_00:  c00_r <= rd_data_r;
        CRN_10:  c10_r <= rd_data_r;
        CRN_01:  c01_r <= rd_data_r;
        default: c11_r <= rd_data_r;
      endcase
    end
    if (cmd.blend_en) begin
      case (cmd.blend_sel)
        BLD_R1:  r1_r <= bl_res;
        BLD_R2:  r2_r <= bl_res;
        default: n_r  <= bl_res;
      endcase
    end
    if (cmd.acc_en) begin
      sum_r   <= sum_r + SUM_W'(wprod);
      total_r <= total_r + TOT_W'(amp_r);
      amp_r   <= aprod[16 +: AMP_W];
    end
    if (cmd.pacc_en) begin
      sm_r <= sm_r + SM_W'(quo[VAL_W-1:0]);
    end
    if (cmd.cap_v) begin
      v_r   <= v;
      cls_r <= cls;
    end
    if (cmd.out_load) begin
      out_noise_r <= v_r;
      out_class_r <= cls_r;
    end
  end

  // Loop counters and result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      di_r        <= '0;
      dj_r        <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.query_init) begin
        di_r <= '0;
        dj_r <= '0;
      end else if (cmd.pt_next) begin
        if ((7'(dj_r) + 7'd1) == win) begin
          dj_r <= '0;
          di_r <= di_r + 1'b1;
        end else begin
          dj_r <= dj_r + 1'b1;
        end
      end
      if (cmd.oct_init) begin
        k_r <= '0;
      end else if (cmd.acc_en) begin
        k_r <= k_r + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_noise = out_noise_r;
  assign out_class = out_class_r;

endmodule

@@ sv/vnc_ctrl.sv @@
// Controller state machine that sequences the window, octave and corner steps.
`timescale 1ns / 1ps
module vnc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start_query,
  input  vnc_pkg::sts_t  sts,
  output vnc_pkg::cmd_t  cmd,
  output logic           idle
);
  import vnc_pkg::*;

  typedef enum logic [23:0] {
    S_IDLE = 24'h000001,
    S_PT   = 24'h000002,
    S_DXS  = 24'h000004,
    S_DXW  = 24'h000008,
    S_DYS  = 24'h000010,
    S_DYW  = 24'h000020,
    S_CAPY = 24'h000040,
    S_R0   = 24'h000080,
    S_R1   = 24'h000100,
    S_R2   = 24'h000200,
    S_R3   = 24'h000400,
    S_R4   = 24'h000800,
    S_B1   = 24'h001000,
    S_B2   = 24'h002000,
    S_B3   = 24'h004000,
    S_ACC  = 24'h008000,
    S_PDS  = 24'h010000,
    S_PDW  = 24'h020000,
    S_PACC = 24'h040000,
    S_NXT  = 24'h080000,
    S_WDS  = 24'h100000,
    S_WDW  = 24'h200000,
    S_FIN  = 24'h400000,
    S_DONE = 24'h800000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start_query) begin
          cmd.query_init = 1'b1;
          state_nxt      = S_PT;
        end
      end
      S_PT: begin
        if (sts.in_range) begin
          cmd.oct_init = 1'b1;
          state_nxt    = S_DXS;
        end else begin
          state_nxt = S_NXT;
        end
      end
      S_DXS: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = DIV_X;
        state_nxt   = S_DXW;
      end
      S_DXW: begin
        if (sts.div_done) begin
          state_nxt = S_DYS;
        end
      end
      S_DYS: begin
        cmd.cap_x   = 1'b1;
        cmd.div_go  = 1'b1;
        cmd.div_sel = DIV_Y;
        state_nxt   = S_DYW;
      end
      S_DYW: begin
        if (sts.div_done) begin
          state_nxt = S_CAPY;
        end
      end
      S_CAPY: begin
        cmd.cap_y = 1'b1;
        state_nxt = S_R0;
      end
      S_R0: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = CRN_00;
        state_nxt  = S_R1;
      end
      S_R1: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = CRN_10;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = CRN_00;
        state_nxt   = S_R2;
      end
      S_R2: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = CRN_01;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = CRN_10;
        state_nxt   = S_R3;
      end
      S_R3: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = CRN_11;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = CRN_01;
        state_nxt   = S_R4;
      end
      S_R4: begin
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = CRN_11;
        state_nxt   = S_B1;
      end
      S_B1: begin
        cmd.blend_en  = 1'b1;
        cmd.blend_sel = BLD_R1;
        state_nxt     = S_B2;
      end
      S_B2: begin
        cmd.blend_en  = 1'b1;
        cmd.blend_sel = BLD_R2;
        state_nxt     = S_B3;
      end
      S_B3: begin
        cmd.blend_en  = 1'b1;
        cmd.blend_sel = BLD_N;
        state_nxt     = S_ACC;
      end
      S_ACC: begin
        cmd.acc_en = 1'b1;
        state_nxt  = sts.last_k ? S_PDS : S_DXS;
      end
      S_PDS: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = DIV_POINT;
        state_nxt   = S_PDW;
      end
      S_PDW: begin
        if (sts.div_done) begin
          state_nxt = S_PACC;
        end
      end
      S_PACC: begin
        cmd.pacc_en = 1'b1;
        state_nxt   = S_NXT;
      end
      S_NXT: begin
        if (sts.last_pt) begin
          state_nxt = S_WDS;
        end else begin
          cmd.pt_next = 1'b1;
          state_nxt   = S_PT;
        end
      end
      S_WDS: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = DIV_WINDOW;
        state_nxt   = S_WDW;
      end
      S_WDW: begin
        if (sts.div_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.cap_v = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign idle = (state_r == S_IDLE);

endmodule

@@ sv/value_noise_octave_tile_classifier_top.sv @@
// Top level of the fractal value noise tile classifier: ports, configuration registers.
`timescale 1ns / 1ps
//
// Channel  Direction  Beat contents
// in_      slave      tuser: action; tdata: lattice_index, lattice_value, coord_x, coord_y
// out_     master     tdata: noise_value, tile_class
// cfg_     slave      cfg_index selects the register, cfg_data carries its value
//
// A write beat stores into the lattice; it gives no result.
// A query walks every point of the t-by-t window; a clipped point does no division,
// and the window average adds one more. The single shared divider, one quotient bit
// a cycle, sets the pace. Reset is synchronous and active low; it restores the
// register defaults and idles the sequencer. The lattice is not cleared. A finished
// result waits in the output register while the next beat is accepted; a stalled
// output only holds the sequencer in its last state, no result is dropped.
module value_noise_octave_tile_classifier_top (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [11:0] lattice_index, [27:12] lattice_value,
                                  // [43:28] coord_x, [59:44] coord_y, [63:60] zero
  input  logic        in_tuser,   // [0] action: 0 lattice write, 1 query
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [15:0] noise_value, [18:16] tile_class, [23:19] zero
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import vnc_pkg::*;

  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;
  logic idle;
  logic in_beat;
  logic [VAL_W-1:0]   noise;
  logic [CLASS_W-1:0] tclass;

  // Registers are always writable; software must write them only while idle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cell_step      <= STEP_W'(16);
      cfg_r.octave_count   <= OCTC_W'(4);
      cfg_r.persistence    <= PERS_W'(32768);
      cfg_r.threshold_low  <= THR_W'(26214);
      cfg_r.threshold_high <= THR_W'(39321);
      cfg_r.window_size    <= WINC_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CELL_STEP:   cfg_r.cell_step      <= cfg_data;
        REG_OCTAVES:     cfg_r.octave_count   <= cfg_data[OCTC_W-1:0];
        REG_PERSISTENCE: cfg_r.persistence    <= cfg_data;
        REG_THR_LOW:     cfg_r.threshold_low  <= cfg_data;
        REG_THR_HIGH:    cfg_r.threshold_high <= cfg_data;
        REG_WINDOW:      cfg_r.window_size    <= cfg_data[WINC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Beats are taken only while the sequencer is idle.
  assign in_tready = idle;
  assign in_beat   = in_tvalid && in_tready;

  vnc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_query (in_beat && in_tuser),
    .sts         (sts),
    .cmd         (cmd),
    .idle        (idle)
  );

  vnc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd       (cmd),
    .sts       (sts),
    .wr_en     (in_beat && !in_tuser),
    .wr_idx    (in_tdata[11:0]),
    .wr_val    (in_tdata[27:12]),
    .coord_x   (in_tdata[43:28]),
    .coord_y   (in_tdata[59:44]),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_noise (noise),
    .out_class (tclass)
  );

  assign out_tdata = {5'b00000, tclass, noise};

endmodule

@@ sv/vnc_checker.sv @@
// Port-level checker for the value noise tile classifier, bound to the top level.
`timescale 1ns / 1ps
module vnc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat withdrawn while stalled");

  // A stalled result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result payload changed while stalled");

  // An accepted query keeps the input closed in the following cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready)
    else $error("input accepted right after a query beat");

  // A new result is only loaded while a query is in flight.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without a query in progress");

endmodule

bind value_noise_octave_tile_classifier_top vnc_checker u_vnc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
